FILE: design/lelm_pkg.sv
`timescale 1ns / 1ps

package lelm_pkg;

  // field widths
  localparam int TIME_W   = 32;
  localparam int STAMP_W  = 33;
  localparam int LAT_W    = 33;
  localparam int THR_W    = 16;
  localparam int WIN_W    = 20;
  localparam int NUM_W    = 16;
  localparam int DEN_W    = 24;
  localparam int CFG_W    = 24;
  localparam int OFF_W    = 48;

  // datapath widths
  localparam int MAG_W    = STAMP_W;            // |stamp difference|
  localparam int ACC_W    = MAG_W + NUM_W;      // mag * num
  localparam int PROD_W   = ACC_W + 10;         // mag * num * 1000
  localparam int WIDE_W   = PROD_W + 2;         // signed offset before saturation

  // iteration counts
  localparam int MUL_STEPS = NUM_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  // register indexes
  localparam logic [1:0] CFG_LAG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd1;
  localparam logic [1:0] CFG_TIMEBASE_NUM  = 2'd2;
  localparam logic [1:0] CFG_TIMEBASE_DEN  = 2'd3;

  // register reset values
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(2500);
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10000);
  localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(1);
  localparam logic [DEN_W-1:0] DEN_RESET = DEN_W'(1000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_SCALE,
    ST_DIV,
    ST_OFFS,
    ST_WIN,
    ST_UPD
  } lelm_state_e;

  typedef struct packed {
    logic load;      // capture input request
    logic prep;      // anchor and stamp difference
    logic mul_step;  // one bit of mag * num
    logic scale;     // times 1000, load divider
    logic div_step;  // one quotient bit
    logic offs;      // offset and window age
    logic win;       // rolling minimum update
    logic emit;      // write result register
  } lelm_cmd_t;

  typedef struct packed {
    logic stamp_valid;
    logic out_free;
  } lelm_status_t;

endpackage

FILE: design/lelm_ctrl.sv
`timescale 1ns / 1ps

module lelm_ctrl
  import lelm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output lelm_cmd_t    cmd_o,
  input  lelm_status_t status_i
);

  lelm_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PREP;
      ST_PREP:  state_d = status_i.stamp_valid ? ST_MUL : ST_UPD;
      ST_MUL:   if (cnt_q == MUL_LAST) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DIV;
      ST_DIV:   if (cnt_q == DIV_LAST) state_d = ST_OFFS;
      ST_OFFS:  state_d = ST_WIN;
      ST_WIN:   state_d = ST_UPD;
      ST_UPD:   if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cnt_d      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_PREP:  cmd_o.prep = status_i.stamp_valid;
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = (cnt_q == MUL_LAST) ? '0 : cnt_q + 1'b1;
      end
      ST_SCALE: cmd_o.scale = 1'b1;
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = (cnt_q == DIV_LAST) ? '0 : cnt_q + 1'b1;
      end
      ST_OFFS:  cmd_o.offs = 1'b1;
      ST_WIN:   cmd_o.win = 1'b1;
      ST_UPD:   cmd_o.emit = status_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

FILE: design/lelm_dpath.sv
`timescale 1ns / 1ps

module lelm_dpath
  import lelm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lelm_cmd_t          cmd_i,
  output lelm_status_t       status_o,
  input  logic [TIME_W-1:0]  arrival_ms_i,
  input  logic [STAMP_W-1:0] decode_stamp_i,
  input  logic               stamp_valid_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [LAT_W-1:0]   latency_ms_o,
  output logic               latency_valid_o,
  output logic               reconnect_o
);

  // configuration
  logic [THR_W-1:0] thr_q;
  logic [WIN_W-1:0] win_len_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;

  // monitor state
  logic                     anchored_q;
  logic [STAMP_W-1:0]       anchor_stamp_q;
  logic [TIME_W-1:0]        anchor_time_q;
  logic [TIME_W-1:0]        win_start_q;
  logic signed [OFF_W-1:0]  cur_min_q;
  logic signed [OFF_W-1:0]  prev_min_q;

  // item payload and working registers
  logic [TIME_W-1:0]        arrival_q;
  logic [STAMP_W-1:0]       stamp_q;
  logic                     svalid_q;
  logic                     neg_q;
  logic [MAG_W-1:0]         mag_q;
  logic [ACC_W-1:0]         acc_q;
  logic [NUM_W-1:0]         nsh_q;
  logic [PROD_W-1:0]        quo_q;
  logic [DEN_W-1:0]         rem_q;
  logic signed [OFF_W-1:0]  offset_q;
  logic                     age_gt_q;
  logic signed [OFF_W-1:0]  min_q;

  // result register
  logic                     out_valid_q;
  logic [LAT_W-1:0]         out_lat_q;
  logic                     out_lv_q;
  logic                     out_rc_q;

  logic                     out_free;
  logic [STAMP_W-1:0]       eff_stamp;
  logic [STAMP_W:0]         diff;
  logic [STAMP_W:0]         diff_neg;
  logic [ACC_W-1:0]         acc_next;
  logic [PROD_W-1:0]        prod;
  logic [DEN_W-1:0]         den_eff;
  logic [DEN_W:0]           trial;
  logic                     qbit;
  logic [TIME_W-1:0]        real_ms;
  logic [TIME_W-1:0]        age;
  logic signed [WIDE_W-1:0] real_wide;
  logic signed [WIDE_W-1:0] q_wide;
  logic signed [WIDE_W-1:0] off_wide;
  logic [WIDE_W-OFF_W:0]    off_hi;
  logic signed [OFF_W-1:0]  off_sat;
  logic signed [OFF_W-1:0]  new_cur;
  logic signed [OFF_W-1:0]  new_prev;
  logic signed [OFF_W:0]    lat_wide;
  logic [OFF_W-1:0]         lat_mag;
  logic [LAT_W-1:0]         lat_sat;
  logic                     lat_over;

  assign out_free             = !out_valid_q || out_ready_i;
  assign status_o.stamp_valid = svalid_q;
  assign status_o.out_free    = out_free;

  // stamp difference against the anchor, or against itself on a fresh anchor
  assign eff_stamp = anchored_q ? anchor_stamp_q : stamp_q;
  assign diff      = {1'b0, stamp_q} - {1'b0, eff_stamp};
  assign diff_neg  = '0 - diff;

  // msb-first shift-add multiply by num
  assign acc_next = {acc_q[ACC_W-2:0], 1'b0} + (nsh_q[NUM_W-1] ? ACC_W'(mag_q) : '0);

  // times 1000 as 1024 - 16 - 8
  assign prod = {acc_q, 10'b0} - PROD_W'({acc_q, 4'b0}) - PROD_W'({acc_q, 3'b0});

  // restoring division, zero denominator taken as one
  assign den_eff = (den_q == '0) ? DEN_W'(1) : den_q;
  assign trial   = {rem_q, quo_q[PROD_W-1]};
  assign qbit    = (trial >= {1'b0, den_eff});

  // offset = real elapsed minus signed stream elapsed, saturated to 48 bits
  assign real_ms   = arrival_q - anchor_time_q;
  assign age       = arrival_q - win_start_q;
  assign real_wide = $signed({{(WIDE_W-TIME_W){1'b0}}, real_ms});
  assign q_wide    = $signed({2'b0, quo_q});
  assign off_wide  = neg_q ? (real_wide + q_wide) : (real_wide - q_wide);
  assign off_hi    = off_wide[WIDE_W-1:OFF_W-1];

  always_comb begin
    if (!off_wide[WIDE_W-1] && (off_hi != '0)) begin
      off_sat = {1'b0, {(OFF_W-1){1'b1}}};
    end else if (off_wide[WIDE_W-1] && (off_hi != '1)) begin
      off_sat = {1'b1, {(OFF_W-1){1'b0}}};
    end else begin
      off_sat = off_wide[OFF_W-1:0];
    end
  end

  // window rotation or running minimum
  always_comb begin
    new_prev = prev_min_q;
    new_cur  = cur_min_q;
    if (age_gt_q) begin
      new_prev = cur_min_q;
      new_cur  = offset_q;
    end else if (offset_q < cur_min_q) begin
      new_cur  = offset_q;
    end
  end

  // latency against the two-window minimum
  assign lat_wide = {offset_q[OFF_W-1], offset_q} - {min_q[OFF_W-1], min_q};
  assign lat_mag  = lat_wide[OFF_W] ? '0 : lat_wide[OFF_W-1:0];
  assign lat_sat  = (lat_mag[OFF_W-1:LAT_W] != '0) ? '1 : lat_mag[LAT_W-1:0];
  assign lat_over = (lat_mag > OFF_W'(thr_q));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THR_RESET;
      win_len_q <= WIN_RESET;
      num_q     <= NUM_RESET;
      den_q     <= DEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LAG_THRESHOLD: thr_q     <= cfg_data_i[THR_W-1:0];
        CFG_WINDOW_LENGTH: win_len_q <= cfg_data_i[WIN_W-1:0];
        CFG_TIMEBASE_NUM:  num_q     <= cfg_data_i[NUM_W-1:0];
        CFG_TIMEBASE_DEN:  den_q     <= cfg_data_i[DEN_W-1:0];
        default: ;
      endcase
    end
  end

  // monitor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchored_q     <= 1'b0;
      anchor_stamp_q <= '0;
      anchor_time_q  <= '0;
      win_start_q    <= '0;
      cur_min_q      <= '0;
      prev_min_q     <= '0;
    end else if (cmd_i.emit && svalid_q && lat_over) begin
      anchored_q     <= 1'b0;
      anchor_stamp_q <= '0;
      anchor_time_q  <= '0;
      win_start_q    <= '0;
      cur_min_q      <= '0;
      prev_min_q     <= '0;
    end else if (cmd_i.prep && !anchored_q) begin
      anchored_q     <= 1'b1;
      anchor_stamp_q <= stamp_q;
      anchor_time_q  <= arrival_q;
      win_start_q    <= arrival_q;
    end else if (cmd_i.win) begin
      cur_min_q  <= new_cur;
      prev_min_q <= new_prev;
      if (age_gt_q) begin
        win_start_q <= arrival_q;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      arrival_q <= arrival_ms_i;
      stamp_q   <= decode_stamp_i;
      svalid_q  <= stamp_valid_i;
    end
    if (cmd_i.prep) begin
      neg_q <= diff[STAMP_W];
      mag_q <= diff[STAMP_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
      acc_q <= '0;
      nsh_q <= num_q;
    end
    if (cmd_i.mul_step) begin
      acc_q <= acc_next;
      nsh_q <= {nsh_q[NUM_W-2:0], 1'b0};
    end
    if (cmd_i.scale) begin
      quo_q <= prod;
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= qbit ? DEN_W'(trial - {1'b0, den_eff}) : trial[DEN_W-1:0];
      quo_q <= {quo_q[PROD_W-2:0], qbit};
    end
    if (cmd_i.offs) begin
      offset_q <= off_sat;
      age_gt_q <= (age > TIME_W'(win_len_q));
    end
    if (cmd_i.win) begin
      min_q <= (new_prev < new_cur) ? new_prev : new_cur;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_lat_q <= svalid_q ? lat_sat : '0;
      out_lv_q  <= svalid_q;
      out_rc_q  <= svalid_q && lat_over;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign latency_ms_o    = out_lat_q;
  assign latency_valid_o = out_lv_q;
  assign reconnect_o     = out_rc_q;

endmodule

FILE: design/live_edge_latency_monitor_unit.sv
`timescale 1ns / 1ps
// a packet with a timestamp goes through prep, multiply, scale, divide, offset, window and update;
// one without goes from prep straight to update; a new packet is taken only after the last one has been written to the
//   result register; the 16-step shift-add multiplier and the 59-step restoring divider both run one bit a cycle
// the result register frees the input side: the next packet is taken while a result waits
// reset (rst_ni low, asynchronous) clears the anchor, both minima and the result register,
//   and loads the registers with threshold 2500, window 10000, timebase 1/1000

module live_edge_latency_monitor_unit
  import lelm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  // packet requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // arrival_ms [31:0], decode_stamp [64:32], zero pad
  input  logic [0:0]  s_axis_tuser,   // stamp_valid [0]

  // result requests
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // latency_ms [32:0], zero pad
  output logic [1:0]  m_axis_tuser,   // latency_valid [0], reconnect [1]

  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  lelm_cmd_t        cmd;
  lelm_status_t     status;
  logic [LAT_W-1:0] latency_ms;
  logic             latency_valid;
  logic             reconnect;

  // the user must change registers only while idle; the block does not enforce it, and writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer: anchor, multiply, scale, divide, offset, window, emit
  lelm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // arithmetic, monitor state, registers and result register
  lelm_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .arrival_ms_i    (s_axis_tdata[TIME_W-1:0]),
    .decode_stamp_i  (s_axis_tdata[TIME_W+STAMP_W-1:TIME_W]),
    .stamp_valid_i   (s_axis_tuser[0]),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .latency_ms_o    (latency_ms),
    .latency_valid_o (latency_valid),
    .reconnect_o     (reconnect)
  );

  assign m_axis_tdata = {7'b0, latency_ms};
  assign m_axis_tuser = {reconnect, latency_valid};

endmodule
